FILE: rtl/cluster_chain_allocator_top_assert.svh
// Assertion macros for the cluster chain allocator.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef CLUSTER_CHAIN_ALLOCATOR_TOP_ASSERT_SVH
`define CLUSTER_CHAIN_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cluster chain allocator: implication check failed");
`define CCA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("cluster chain allocator: forbidden condition seen");
`else
`define CCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CCA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: rtl/cca_pkg.sv
// Shared types and constants for the cluster chain allocator.
// No dependencies; imported by the table memory and the top level.
package cca_pkg;

  localparam int          DEPTH_DEF         = 128;
  localparam logic [7:0]  CLUSTER_COUNT_RST = 8'd87;
  localparam logic [7:0]  ENTRY_FREE        = 8'hFE;
  localparam logic [7:0]  ENTRY_END         = 8'hFD;
  localparam logic [16:0] CLUSTER_ROUND     = 17'd1023;

  typedef enum logic [2:0] {
    MODE_FORMAT = 3'd0,
    MODE_LOAD   = 3'd1,
    MODE_READ   = 3'd2,
    MODE_ALLOC  = 3'd3,
    MODE_FREE   = 3'd4,
    MODE_CHECK  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_CORRUPT = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FMT,
    S_RD_D,
    S_FR_A,
    S_FR_D,
    S_FW_A,
    S_FW_D,
    S_CK_A,
    S_CK_D,
    S_AS_A,
    S_AS_D,
    S_AL_A,
    S_AL_D,
    S_AL_END,
    S_RC,
    S_OUT,
    S_EM_A,
    S_EM_D
  } state_t;

endpackage

FILE: rtl/cca_if.sv
// Valid/ready channel interfaces for the cluster chain allocator.
// Request and result beats; no dependencies.
interface cca_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [6:0] index;
  logic [7:0] value;
  logic [15:0] byte_length;
  logic       first_of_pass;

  modport source(output valid, mode, index, value, byte_length, first_of_pass,
                 input ready);
  modport sink(input valid, mode, index, value, byte_length, first_of_pass,
               output ready);
endinterface

interface cca_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] cluster;
  logic [7:0] chain_length;
  logic [7:0] free_count;
  logic       last;

  modport source(output valid, status, cluster, chain_length, free_count, last,
                 input ready);
  modport sink(input valid, status, cluster, chain_length, free_count, last,
               output ready);
endinterface

FILE: rtl/cca_table.sv
// Link table memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses cca_pkg.
module cca_table #(
  parameter int TABLE_DEPTH = cca_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           we,
  input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
  input  logic [7:0]                     wdata,
  input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
  output logic [7:0]                     rdata
);
  import cca_pkg::*;

  logic [7:0]             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [7:0]             rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= vld_r[raddr] ? mem[raddr] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/cluster_chain_allocator_top.sv
// Cluster chain allocator: link table with allocate, free and check walks.
// Uses cca_pkg, cca_in_if/cca_out_if, cca_table and the assertion macros.
//
// Usage:
//  - in_ch carries one request beat (mode, index, value, byte_length,
//    first_of_pass); it is taken when valid and ready are both high.
//  - out_ch carries result beats; a successful allocate gives one beat per
//    cluster, the final one with last set; every other case gives a single beat.
//  - cfg_wr_en/cfg_wr_data write cluster_count; write it only while idle.
//  - One request is in flight at a time: ready is high only while idle.
//  - Every chain step is a read of the single memory port, issued in an
//    address state and used in a data state. After the operation the free
//    count is rebuilt by a sweep of min(cluster_count, TABLE_DEPTH) entries
//    (about one per cycle). Format writes all TABLE_DEPTH entries first;
//    free walks the chain twice, to verify and then to write free; allocate
//    scans the table in two passes, then emits each cluster by following
//    the new chain after the recount.
//  - Reset: table reads as zero, marks clear, cluster_count is 87.
//  - A stalled receiver simply holds the result beat; nothing is lost.
module cluster_chain_allocator_top #(
  parameter int TABLE_DEPTH = cca_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  cca_in_if.sink          in_ch,
  cca_out_if.source       out_ch,
  input  logic            cfg_wr_en,
  input  logic [7:0]      cfg_wr_data
);
  import cca_pkg::*;

  localparam int         AW     = $clog2(TABLE_DEPTH);
  localparam logic [7:0] DEPTH8 = 8'(TABLE_DEPTH);

  state_t                 state_r, state_nxt;
  logic [7:0]             cluster_count_r;
  logic [7:0]             eff_cnt;
  logic [7:0]             cnt_r, cnt_nxt;
  logic [7:0]             c_r, c_nxt;
  logic [7:0]             i_r, i_nxt;
  logic [7:0]             len_r, len_nxt;
  logic [6:0]             need_r, need_nxt;
  logic [6:0]             k_r, k_nxt;
  logic [AW-1:0]          first_r, first_nxt;
  logic [AW-1:0]          prev_r, prev_nxt;
  logic [6:0]             idx_r, idx_nxt;
  logic [7:0]             fc_r, fc_nxt;
  logic                   pend_r, pend_nxt;
  logic                   alloc_ok_r, alloc_ok_nxt;
  status_t                st_r, st_nxt;
  logic [7:0]             clus_r, clus_nxt;
  logic [7:0]             free_r, free_nxt;
  logic                   last_r, last_nxt;
  logic [TABLE_DEPTH-1:0] walk_marks_r, walk_marks_nxt;
  logic [TABLE_DEPTH-1:0] pass_marks_r, pass_marks_nxt;

  logic                   t_we;
  logic [AW-1:0]          t_waddr;
  logic [7:0]             t_wdata;
  logic [AW-1:0]          t_raddr;
  logic [7:0]             t_rdata;
  logic [16:0]            round_sum;
  logic [6:0]             need_in;

  cca_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // Clamp the configured count to the table size.
  assign eff_cnt   = (cluster_count_r > DEPTH8) ? DEPTH8 : cluster_count_r;
  // Round byte length up to 1 KiB clusters; zero bytes still takes one.
  assign round_sum = 17'(in_ch.byte_length) + CLUSTER_ROUND;
  assign need_in   = (in_ch.byte_length == 16'd0) ? 7'd1 : round_sum[16:10];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r <= CLUSTER_COUNT_RST;
    end else if (cfg_wr_en) begin
      cluster_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      walk_marks_r <= '0;
      pass_marks_r <= '0;
      pend_r       <= 1'b0;
      alloc_ok_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      walk_marks_r <= walk_marks_nxt;
      pass_marks_r <= pass_marks_nxt;
      pend_r       <= pend_nxt;
      alloc_ok_r   <= alloc_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    c_r     <= c_nxt;
    i_r     <= i_nxt;
    len_r   <= len_nxt;
    need_r  <= need_nxt;
    k_r     <= k_nxt;
    first_r <= first_nxt;
    prev_r  <= prev_nxt;
    idx_r   <= idx_nxt;
    fc_r    <= fc_nxt;
    st_r    <= st_nxt;
    clus_r  <= clus_nxt;
    free_r  <= free_nxt;
    last_r  <= last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    c_nxt          = c_r;
    i_nxt          = i_r;
    len_nxt        = len_r;
    need_nxt       = need_r;
    k_nxt          = k_r;
    first_nxt      = first_r;
    prev_nxt       = prev_r;
    idx_nxt        = idx_r;
    fc_nxt         = fc_r;
    pend_nxt       = pend_r;
    alloc_ok_nxt   = alloc_ok_r;
    st_nxt         = st_r;
    clus_nxt       = clus_r;
    free_nxt       = free_r;
    last_nxt       = last_r;
    walk_marks_nxt = walk_marks_r;
    pass_marks_nxt = pass_marks_r;
    t_we           = 1'b0;
    t_waddr        = c_r[AW-1:0];
    t_wdata        = ENTRY_FREE;
    t_raddr        = c_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cnt_nxt      = eff_cnt;
          idx_nxt      = in_ch.index;
          c_nxt        = {1'b0, in_ch.index};
          i_nxt        = 8'd0;
          k_nxt        = 7'd0;
          len_nxt      = 8'd0;
          st_nxt       = ST_OK;
          clus_nxt     = 8'd0;
          alloc_ok_nxt = 1'b0;
          need_nxt     = need_in;
          unique case (mode_t'(in_ch.mode))
            MODE_FORMAT: state_nxt = S_FMT;
            MODE_LOAD: begin
              // Drop loads beyond the table.
              if ({1'b0, in_ch.index} < DEPTH8) begin
                t_we    = 1'b1;
                t_waddr = in_ch.index[AW-1:0];
                t_wdata = in_ch.value;
              end
              state_nxt = S_RC;
            end
            MODE_READ: begin
              t_raddr = in_ch.index[AW-1:0];
              if ({1'b0, in_ch.index} < DEPTH8) begin
                state_nxt = S_RD_D;
              end else begin
                state_nxt = S_RC;
              end
            end
            MODE_ALLOC: state_nxt = S_AS_A;
            MODE_FREE:  state_nxt = S_FR_A;
            MODE_CHECK: begin
              if (in_ch.first_of_pass) begin
                pass_marks_nxt = '0;
              end
              state_nxt = S_CK_A;
            end
            default: state_nxt = S_RC;
          endcase
        end
      end

      S_FMT: begin
        t_we    = 1'b1;
        t_waddr = i_r[AW-1:0];
        t_wdata = (i_r < cnt_r) ? ENTRY_FREE : 8'd0;
        i_nxt   = i_r + 8'd1;
        if (i_r == DEPTH8 - 8'd1) begin
          state_nxt = S_RC;
        end
      end

      S_RD_D: begin
        clus_nxt  = t_rdata;
        state_nxt = S_RC;
      end

      // Free: verify the whole chain first, then rewalk it writing free.
      S_FR_A: begin
        if (c_r >= cnt_r) begin
          st_nxt         = ST_CORRUPT;
          len_nxt        = 8'd0;
          walk_marks_nxt = '0;
          state_nxt      = S_RC;
        end else begin
          state_nxt = S_FR_D;
        end
      end

      S_FR_D: begin
        if ((t_rdata >= cnt_r && t_rdata != ENTRY_END) || walk_marks_r[c_r[AW-1:0]]) begin
          st_nxt         = ST_CORRUPT;
          len_nxt        = 8'd0;
          walk_marks_nxt = '0;
          state_nxt      = S_RC;
        end else begin
          walk_marks_nxt[c_r[AW-1:0]] = 1'b1;
          len_nxt = len_r + 8'd1;
          if (t_rdata == ENTRY_END) begin
            c_nxt     = {1'b0, idx_r};
            state_nxt = S_FW_A;
          end else begin
            c_nxt     = t_rdata;
            state_nxt = S_FR_A;
          end
        end
      end

      S_FW_A: state_nxt = S_FW_D;

      S_FW_D: begin
        t_we    = 1'b1;
        t_waddr = c_r[AW-1:0];
        t_wdata = ENTRY_FREE;
        c_nxt   = t_rdata;
        if (t_rdata == ENTRY_END) begin
          walk_marks_nxt = '0;
          state_nxt      = S_RC;
        end else begin
          state_nxt = S_FW_A;
        end
      end

      // Check: marks persist across the pass; fault keeps partial length.
      S_CK_A: begin
        if (c_r >= cnt_r || pass_marks_r[c_r[AW-1:0]]) begin
          st_nxt    = ST_CORRUPT;
          state_nxt = S_RC;
        end else begin
          pass_marks_nxt[c_r[AW-1:0]] = 1'b1;
          len_nxt   = len_r + 8'd1;
          state_nxt = S_CK_D;
        end
      end

      S_CK_D: begin
        c_nxt = t_rdata;
        if (t_rdata == ENTRY_END) begin
          state_nxt = S_RC;
        end else begin
          state_nxt = S_CK_A;
        end
      end

      // Allocate, pass one: make sure enough free clusters exist.
      S_AS_A: begin
        t_raddr = i_r[AW-1:0];
        if (i_r >= cnt_r) begin
          st_nxt    = ST_FULL;
          state_nxt = S_RC;
        end else begin
          state_nxt = S_AS_D;
        end
      end

      S_AS_D: begin
        i_nxt     = i_r + 8'd1;
        state_nxt = S_AS_A;
        if (t_rdata == ENTRY_FREE) begin
          k_nxt = k_r + 7'd1;
          if (k_r == 7'd0) begin
            first_nxt = i_r[AW-1:0];
          end
          if (k_r + 7'd1 == need_r) begin
            k_nxt    = 7'd1;
            prev_nxt = (k_r == 7'd0) ? i_r[AW-1:0] : first_r;
            i_nxt    = ((k_r == 7'd0) ? i_r : 8'(first_r)) + 8'd1;
            if (need_r == 7'd1) begin
              state_nxt = S_AL_END;
            end else begin
              state_nxt = S_AL_A;
            end
          end
        end
      end

      // Allocate, pass two: link each free cluster to the next one.
      S_AL_A: begin
        t_raddr   = i_r[AW-1:0];
        state_nxt = S_AL_D;
      end

      S_AL_D: begin
        i_nxt     = i_r + 8'd1;
        state_nxt = S_AL_A;
        if (t_rdata == ENTRY_FREE) begin
          t_we     = 1'b1;
          t_waddr  = prev_r;
          t_wdata  = i_r;
          prev_nxt = i_r[AW-1:0];
          k_nxt    = k_r + 7'd1;
          if (k_r + 7'd1 == need_r) begin
            state_nxt = S_AL_END;
          end
        end
      end

      S_AL_END: begin
        t_we         = 1'b1;
        t_waddr      = prev_r;
        t_wdata      = ENTRY_END;
        len_nxt      = 8'(need_r);
        c_nxt        = 8'(first_r);
        alloc_ok_nxt = 1'b1;
        state_nxt    = S_RC;
      end

      // Recount free entries, one read issued per cycle.
      S_RC: begin
        t_raddr = i_r[AW-1:0];
        if (pend_r && t_rdata == ENTRY_FREE) begin
          fc_nxt = fc_r + 8'd1;
        end
        if (i_r < cnt_r) begin
          i_nxt    = i_r + 8'd1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            free_nxt = fc_r;
            if (alloc_ok_r) begin
              state_nxt = S_EM_A;
            end else begin
              last_nxt  = 1'b1;
              state_nxt = S_OUT;
            end
          end
        end
      end

      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = last_r ? S_IDLE : S_EM_A;
        end
      end

      // Emit allocated clusters by following the fresh chain.
      S_EM_A: state_nxt = S_EM_D;

      S_EM_D: begin
        clus_nxt  = c_r;
        c_nxt     = t_rdata;
        last_nxt  = (t_rdata == ENTRY_END);
        state_nxt = S_OUT;
      end

      default: state_nxt = S_IDLE;
    endcase

    // Start every recount sweep from entry zero.
    if (state_nxt == S_RC && state_r != S_RC) begin
      i_nxt    = 8'd0;
      fc_nxt   = 8'd0;
      pend_nxt = 1'b0;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = (state_r == S_OUT);
  assign out_ch.status       = st_r;
  assign out_ch.cluster      = clus_r;
  assign out_ch.chain_length = len_r;
  assign out_ch.free_count   = free_r;
  assign out_ch.last         = last_r;

`include "cluster_chain_allocator_top_assert.svh"

  `CCA_ASSERT_NEVER(a_one_side, clk, rst_n, in_ch.ready && out_ch.valid)
  `CCA_ASSERT_IMP(a_free_bound, clk, rst_n, out_ch.valid, out_ch.free_count <= cnt_r)
  `CCA_ASSERT_IMP(a_full_single, clk, rst_n, out_ch.valid && out_ch.status == ST_FULL, out_ch.last && out_ch.chain_length == 8'd0)
  `CCA_ASSERT_IMP(a_walk_clear, clk, rst_n, state_r == S_IDLE, walk_marks_r == '0)

endmodule
